>>> rtl/core/topk_score_select_unit_defines.svh
// Assertion macros shared by the checker files of the top-k score selection unit.
// Depends on nothing; include it by its bare file name.
`ifndef TOPK_SCORE_SELECT_UNIT_DEFINES_SVH
`define TOPK_SCORE_SELECT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("topk score select check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("topk score select check failed");

`endif

>>> rtl/core/tss_pkg.sv
// Shared constants of the top-k score selection unit: register map and reset values.
// Depends on nothing.
`timescale 1ns / 1ps

package tss_pkg;

   // Control and status register port geometry.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register indexes (byte address is four times the index).
   typedef enum logic [0:0] {
      CSR_IDX_KEEP_COUNT = 1'b0
   } csr_index_type;

   // Width and reset value of the keep count register.
   localparam int          KEEP_W     = 5;
   localparam logic [4:0]  KEEP_RESET = 5'd5;

endpackage

>>> rtl/core/topk_score_select_unit.sv
// Top level of the top-k score selection unit: ranked list, insertion logic,
// result drain buffer and control register port. Depends on tss_pkg.
`timescale 1ns / 1ps

// The unit takes one class score per transfer and keeps the highest keep_count
// scores of the current row together with their positions in the row, ranked
// by descending score; on equal scores the earlier position ranks first and a
// newcomer never displaces an equal kept score. One score is accepted in every
// cycle, but for a row_last held as described below: the ranked list is a bank
// of registers and the compare-and-insert for each score is a single parallel
// compare against all kept entries. When the transfer that carries row_last is
// accepted, the finished list is copied into a drain buffer, the ranked list
// clears at once, and the next row may start in the following cycle. The drain
// buffer hands out one result per cycle while rsp_ready is high, best first,
// with result_last on the lowest-ranked one. A transfer with row_last is
// accepted once the previous row has drained, or in the same cycle as the
// transfer of that row's last result. A short row that follows a row with more
// results is therefore held at its row_last until those results have left,
// one per cycle when the result side never stalls.
// A keep_count of zero yields no results; values above MAX_K act as MAX_K.
// Scores at positions MAX_CLASSES and beyond are ignored, though their
// row_last still closes the row. keep_count is at byte address 0 and should
// be written only while no row is open.
module topk_score_select_unit #(
   parameter int MAX_K       = 16,
   parameter int MAX_CLASSES = 1024,
   parameter int SCORE_WIDTH = 16,
   localparam int IDX_W      = $clog2(MAX_CLASSES)
) (
   input  logic                                clock,
   input  logic                                reset,
   // Score input channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SCORE_WIDTH-1:0]       req_score,
   input  logic                                req_row_last,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [IDX_W-1:0]             rsp_class_index,
   output logic signed [SCORE_WIDTH-1:0]       rsp_kept_score,
   output logic                                rsp_result_last,
   // Control register port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic        [tss_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic        [tss_pkg::CSR_DATA_W-1:0] pwdata,
   output logic        [tss_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);
   import tss_pkg::*;

   // Count widths: KW holds 0..MAX_K, POS_W holds 0..MAX_CLASSES.
   localparam int KW    = $clog2(MAX_K + 1);
   localparam int POS_W = $clog2(MAX_CLASSES + 1);

   // Keep count register.
   logic [KEEP_W-1:0] keep_ff;
   logic              csr_write;
   logic              csr_hit;

   // Ranked list; entries at or above the fill count hold stale data.
   logic signed [SCORE_WIDTH-1:0] kept_score_ff [MAX_K];
   logic        [IDX_W-1:0]       kept_index_ff [MAX_K];
   logic signed [SCORE_WIDTH-1:0] kept_score_in [MAX_K];
   logic        [IDX_W-1:0]       kept_index_in [MAX_K];
   logic        [KW-1:0]          fill_ff;
   logic        [POS_W-1:0]       row_pos_ff;

   // Drain buffer; entry 0 is the result on offer.
   logic signed [SCORE_WIDTH-1:0] drain_score_ff [MAX_K];
   logic        [IDX_W-1:0]       drain_index_ff [MAX_K];
   logic        [KW-1:0]          drain_cnt_ff;

   // Insertion decode.
   logic [31:0]      keep_ext;
   logic [KW-1:0]    k_eff;
   logic [KW-1:0]    fill_eff;
   logic [KW-1:0]    fill_new;
   logic [MAX_K-1:0] in_list;
   logic [MAX_K-1:0] lt;
   logic [MAX_K-1:0] ge;
   logic             in_range;
   logic             do_ins;
   logic             grow;
   logic             req_xfer;
   logic             rsp_xfer;
   logic [IDX_W-1:0] new_index;

   // ------------------------------------------------------------------
   // Control register port. Writes complete in the access phase; reads
   // return the register, and addresses beyond the map read as zero.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_KEEP_COUNT);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata    = csr_hit ? CSR_DATA_W'(keep_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= KEEP_RESET;
      end else if (csr_write) begin
         keep_ff <= pwdata[KEEP_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Handshakes. A row close loads the drain buffer, so it needs the buffer
   // empty or its last result leaving at the same edge.
   // ------------------------------------------------------------------
   assign req_ready = !req_row_last || (drain_cnt_ff == '0) ||
                      ((drain_cnt_ff == KW'(1)) && rsp_ready);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = (drain_cnt_ff != '0);
   assign rsp_xfer  = rsp_valid && rsp_ready;

   assign rsp_class_index = drain_index_ff[0];
   assign rsp_kept_score  = drain_score_ff[0];
   assign rsp_result_last = (drain_cnt_ff == KW'(1));

   // ------------------------------------------------------------------
   // Compare and insert. Because the list is sorted, the entries that rank
   // at or above the new score form a prefix; the new score goes in right
   // after that prefix and everything below moves down one place.
   // ------------------------------------------------------------------
   always_comb begin
      keep_ext  = 32'(keep_ff);
      k_eff     = (keep_ext >= 32'(MAX_K)) ? KW'(MAX_K) : keep_ext[KW-1:0];
      fill_eff  = (fill_ff > k_eff) ? k_eff : fill_ff;
      in_range  = (row_pos_ff < POS_W'(MAX_CLASSES));
      new_index = row_pos_ff[IDX_W-1:0];

      for (int i = 0; i < MAX_K; i++) begin
         in_list[i] = (KW'(i) < fill_eff);
         lt[i]      = in_list[i] && (kept_score_ff[i] < req_score);
         ge[i]      = in_list[i] && !lt[i];
      end

      // A full list takes the score only if it beats the current minimum.
      grow     = in_range && (k_eff != '0) && (fill_eff < k_eff);
      do_ins   = in_range && (k_eff != '0) && ((fill_eff < k_eff) || (|lt));
      fill_new = fill_eff + KW'(grow);

      kept_score_in[0] = kept_score_ff[0];
      kept_index_in[0] = kept_index_ff[0];
      if (do_ins && !ge[0]) begin
         kept_score_in[0] = req_score;
         kept_index_in[0] = new_index;
      end
      for (int i = 1; i < MAX_K; i++) begin
         kept_score_in[i] = kept_score_ff[i];
         kept_index_in[i] = kept_index_ff[i];
         if (do_ins && !ge[i]) begin
            if (ge[i-1]) begin
               kept_score_in[i] = req_score;
               kept_index_in[i] = new_index;
            end else begin
               kept_score_in[i] = kept_score_ff[i-1];
               kept_index_in[i] = kept_index_ff[i-1];
            end
         end
      end
   end

   // List contents carry no reset; only the fill count marks what is valid.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         for (int i = 0; i < MAX_K; i++) begin
            kept_score_ff[i] <= kept_score_in[i];
            kept_index_ff[i] <= kept_index_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         row_pos_ff <= '0;
      end else if (req_xfer) begin
         if (req_row_last) begin
            fill_ff    <= '0;
            row_pos_ff <= '0;
         end else begin
            fill_ff <= fill_new;
            if (in_range) begin
               row_pos_ff <= row_pos_ff + POS_W'(1);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Drain buffer. A row close loads the finished list, including the
   // score that closed the row; each result transfer shifts it by one.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         drain_cnt_ff <= '0;
      end else if (req_xfer && req_row_last) begin
         drain_cnt_ff <= fill_new;
      end else if (rsp_xfer) begin
         drain_cnt_ff <= drain_cnt_ff - KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && req_row_last) begin
         for (int i = 0; i < MAX_K; i++) begin
            drain_score_ff[i] <= kept_score_in[i];
            drain_index_ff[i] <= kept_index_in[i];
         end
      end else if (rsp_xfer) begin
         for (int i = 0; i < MAX_K - 1; i++) begin
            drain_score_ff[i] <= drain_score_ff[i+1];
            drain_index_ff[i] <= drain_index_ff[i+1];
         end
      end
   end

endmodule

>>> rtl/core/tss_checker.sv
// Port-level checks for the top-k score selection unit, bound to its top level.
// Depends on topk_score_select_unit_defines.svh and topk_score_select_unit.
`timescale 1ns / 1ps
`include "topk_score_select_unit_defines.svh"

module tss_checker #(
   parameter int SCORE_WIDTH = 16,
   parameter int IDX_W       = 10
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_row_last,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic        [IDX_W-1:0]       rsp_class_index,
   input logic signed [SCORE_WIDTH-1:0] rsp_kept_score,
   input logic                          rsp_result_last
);

   logic req_close;
   logic rsp_mid;

   assign req_close = req_valid && req_ready && req_row_last;
   assign rsp_mid   = rsp_valid && rsp_ready && !rsp_result_last;

   // A stalled result holds still.
   `TSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_class_index) && $stable(rsp_kept_score) && $stable(rsp_result_last))

   // A row closes only once the previous row has drained or its last result is leaving.
   `TSS_ASSERT_SAME(a_close_when_drained, clock, reset, req_close,
      !rsp_valid || (rsp_result_last && rsp_ready))

   // Results of a row come without gaps until the one marked last.
   `TSS_ASSERT_NEXT(a_row_continues, clock, reset, rsp_mid, rsp_valid)

   // Results of a row come in descending score order.
   `TSS_ASSERT_NEXT(a_descending, clock, reset, rsp_mid,
      $signed($past(rsp_kept_score)) >= rsp_kept_score)

   // Results appear only after a row close.
   `TSS_ASSERT_NEXT(a_no_spurious, clock, reset, !rsp_valid && !req_close, !rsp_valid)

endmodule

bind topk_score_select_unit tss_checker #(
   .SCORE_WIDTH(SCORE_WIDTH),
   .IDX_W(IDX_W)
) u_tss_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_row_last(req_row_last),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_class_index(rsp_class_index),
   .rsp_kept_score(rsp_kept_score),
   .rsp_result_last(rsp_result_last)
);

>>> bench/tb_topk_score_select_unit.sv
// Self-checking bench for the top-k score selection unit: score rows go in, ranked results
// are predicted and checked. Depends on tss_pkg and topk_score_select_unit.
`timescale 1ns / 1ps

module tb_topk_score_select_unit;
   import tss_pkg::*;

   // Geometry of the default build of the unit.
   localparam int SCORE_W    = 16;
   localparam int INDEX_W    = 10;
   localparam int RANK_DEPTH = 16;
   localparam int ROW_LIMIT  = 1024;

   // The watchdog fires after this many cycles without any transfer.
   localparam int WATCHDOG_LIMIT = 4000;
   // Quiet cycles granted after the last expected result, covering the drain buffer.
   localparam int DRAIN_PAUSE    = RANK_DEPTH + 8;

   localparam logic [CSR_ADDR_W-1:0] KEEP_COUNT_ADDR = CSR_ADDR_W'(4 * CSR_IDX_KEEP_COUNT);

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7FFF;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;

   // Score mixes used when a row is made up at random.
   typedef enum int {
      SCORES_FULL_RANGE,
      SCORES_CLUSTERED,
      SCORES_EXTREME,
      SCORES_MIXED
   } score_mix_type;

   typedef struct packed {
      logic        [INDEX_W-1:0] class_index;
      logic signed [SCORE_W-1:0] kept_score;
      logic                      result_last;
   } ranked_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [SCORE_W-1:0]           req_score = '0;
   logic                                req_row_last = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic        [INDEX_W-1:0]           rsp_class_index;
   logic signed [SCORE_W-1:0]           rsp_kept_score;
   logic                                rsp_result_last;
   logic                                psel = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite = 1'b0;
   logic        [CSR_ADDR_W-1:0]        paddr = '0;
   logic        [CSR_DATA_W-1:0]        pwdata = '0;
   logic        [CSR_DATA_W-1:0]        prdata;
   logic                                pready;

   topk_score_select_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_score       (req_score),
      .req_row_last    (req_row_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_class_index (rsp_class_index),
      .rsp_kept_score  (rsp_kept_score),
      .rsp_result_last (rsp_result_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #6 clock = ~clock;

   // Shadow of the unit's ranked list. Entries at or above rank_fill are never read, so
   // they need no reset value.
   logic signed [SCORE_W-1:0] rank_score [RANK_DEPTH];
   logic        [INDEX_W-1:0] rank_index [RANK_DEPTH];
   int                        rank_fill = 0;
   int                        row_pos = 0;
   logic        [KEEP_W-1:0]  keep_setting = KEEP_RESET;

   // Results owed by rows already closed, oldest first.
   ranked_result_type ranked_results_due[$];

   int mismatch_count  = 0;
   int scores_sent     = 0;
   int rows_closed     = 0;
   int results_checked = 0;
   int keep_writes     = 0;
   int burst_left      = 0;
   int quiet_cycles    = 0;

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("MISMATCH at %0t: %s", $realtime, what);
      end
   endtask

   // Opens a slot at pos by pushing the entries from pos up to last_slot one place down;
   // whatever sat at last_slot falls off when the list is full.
   task automatic insert_rank(input int pos, input int last_slot,
                              input logic signed [SCORE_W-1:0] s, input int idx);
      for (int i = last_slot; i > pos; i--) begin
         rank_score[i] = rank_score[i-1];
         rank_index[i] = rank_index[i-1];
      end
      rank_score[pos] = s;
      rank_index[pos] = INDEX_W'(idx);
   endtask

   // Applies one accepted score to the shadow list and, on the last score of a row,
   // queues the ranked results that the unit owes.
   task automatic rank_new_score(input logic signed [SCORE_W-1:0] s, input logic last);
      int                limit;
      int                pos;
      ranked_result_type r;
      // A keep count above the list depth acts as the full depth.
      limit = (keep_setting > RANK_DEPTH) ? RANK_DEPTH : int'(keep_setting);
      if (rank_fill > limit) rank_fill = limit;
      // Positions at or past the class limit are ignored, but their row_last still counts.
      if (row_pos < ROW_LIMIT) begin
         if (limit > 0) begin
            // The newcomer goes below every kept entry of equal score.
            pos = 0;
            while (pos < rank_fill && rank_score[pos] >= s) pos++;
            if (rank_fill < limit) begin
               insert_rank(pos, rank_fill, s, row_pos);
               rank_fill++;
            end else if (s > rank_score[rank_fill-1]) begin
               insert_rank(pos, rank_fill - 1, s, row_pos);
            end
         end
         row_pos++;
      end
      if (last) begin
         for (int i = 0; i < rank_fill; i++) begin
            r.class_index = rank_index[i];
            r.kept_score  = rank_score[i];
            r.result_last = (i == rank_fill - 1);
            ranked_results_due = {ranked_results_due, r};
         end
         rank_fill = 0;
         row_pos   = 0;
         rows_closed++;
      end
   endtask

   // Sends one score transfer. The sender runs in bursts of random length; between bursts
   // valid drops for a random gap, and sometimes the next burst follows with no gap at all.
   // Called at a falling edge and returns at a falling edge with valid still high.
   task automatic send_score(input logic signed [SCORE_W-1:0] s, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid    = 1'b1;
      req_score    = s;
      req_row_last = last;
      do @(posedge clock); while (!req_ready);
      rank_new_score(s, last);
      scores_sent++;
      @(negedge clock);
   endtask

   function automatic logic signed [SCORE_W-1:0] pick_score(input score_mix_type mix);
      score_mix_type m;
      m = (mix == SCORES_MIXED) ? score_mix_type'($urandom_range(0, 2)) : mix;
      case (m)
         // A narrow band produces many ties.
         SCORES_CLUSTERED: return SCORE_W'(int'($urandom_range(0, 6)) - 3);
         SCORES_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return SCORE_MAX;
               1:       return SCORE_MIN;
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return SCORE_W'($urandom);
      endcase
   endfunction

   task automatic send_random_row(input int length, input score_mix_type mix);
      for (int i = 0; i < length; i++) begin
         send_score(pick_score(mix), i == length - 1);
      end
   endtask

   // Lowers valid, waits for every owed result, then lets the drain buffer settle.
   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (ranked_results_due.size() != 0) @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
   endtask

   task automatic check_keep_count_readback();
      logic [CSR_DATA_W-1:0] seen;
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = KEEP_COUNT_ADDR;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      seen = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (seen !== CSR_DATA_W'(keep_setting)) begin
         note_mismatch($sformatf("keep_count read: expected %0d, got %0h", keep_setting, seen));
      end
   endtask

   // Writes keep_count only once the unit is idle, then reads it back.
   task automatic write_keep_count(input logic [KEEP_W-1:0] value);
      wait_for_drain();
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = KEEP_COUNT_ADDR;
      pwdata  = CSR_DATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      keep_setting = value;
      keep_writes++;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      check_keep_count_readback();
   endtask

   // Reset value of the register, then a write at the top of its range and back.
   task automatic test_register_access();
      check_keep_count_readback();
      write_keep_count(5'd31);
      write_keep_count(KEEP_RESET);
   endtask

   // Hand-built rows with keep_count at five: score extremes, ties, a one-score row and
   // a row of rising scores whose last displaces the current minimum of the full list.
   task automatic test_directed_rows();
      logic signed [SCORE_W-1:0] mixed_row [8];
      mixed_row = '{SCORE_MAX, SCORE_MIN, 16'sd0, -16'sd1, SCORE_MAX, 16'sd1, SCORE_MIN, 16'sd0};
      foreach (mixed_row[i]) send_score(mixed_row[i], i == 7);
      // A row of one score closes at once.
      send_score(SCORE_MIN, 1'b1);
      // Six equal scores: the sixth must not displace any of the first five.
      for (int i = 0; i < 6; i++) send_score(-16'sd5, i == 5);
      // Rising scores push out the minimum each time the list is full.
      for (int i = 0; i < 6; i++) send_score(SCORE_W'(i), i == 5);
   endtask

   // A row running past the class limit. The four best scores sit just below the limit;
   // the even larger scores beyond it must be ignored, while the row_last on the final,
   // ignored position still closes the row.
   task automatic test_long_row();
      logic signed [SCORE_W-1:0] s;
      write_keep_count(5'd4);
      for (int p = 0; p < ROW_LIMIT + 6; p++) begin
         if (p >= ROW_LIMIT) begin
            s = SCORE_MAX;
         end else if (p >= ROW_LIMIT - 4) begin
            s = SCORE_W'(30000 + p - (ROW_LIMIT - 4));
         end else begin
            s = SCORE_W'(int'($urandom_range(0, 29000)) - 32768);
         end
         send_score(s, p == ROW_LIMIT + 5);
      end
   endtask

   // Random rows under a sweep of keep_count values: zero, one, the list depth, values
   // that saturate, and a few in between. Most rows are short, some exceed the depth.
   task automatic test_random_rows();
      logic [KEEP_W-1:0] sweep [8];
      int                sent_here;
      int                length;
      sweep    = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd2, 5'd5, 5'd9};
      sweep[7] = KEEP_W'($urandom_range(1, 15));
      foreach (sweep[n]) begin
         write_keep_count(sweep[n]);
         sent_here = 0;
         while (sent_here < 62) begin
            length = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 40)
                                                 : $urandom_range(1, 20);
            send_random_row(length, score_mix_type'($urandom_range(0, 3)));
            sent_here += length;
         end
      end
   endtask

   // The receiver stalls on a rotating 16-bit pattern that is redrawn whenever pattern_age
   // reaches its limit: sometimes always ready, sometimes sparse, dense or plain random.
   // Bit 0 is forced on so a pattern never stalls for good.
   logic [15:0] ready_pattern = 16'hFFFF;
   int          pattern_age = 0;

   always @(negedge clock) begin
      rsp_ready     = ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      pattern_age++;
      if (pattern_age == 48) begin
         pattern_age = 0;
         case ($urandom_range(0, 3))
            0:       ready_pattern = 16'hFFFF;
            1:       ready_pattern = 16'($urandom);
            2:       ready_pattern = 16'($urandom & $urandom);
            default: ready_pattern = 16'($urandom | $urandom);
         endcase
         ready_pattern[0] = 1'b1;
      end
   end

   // Each result transfer is checked against the oldest owed result.
   always @(posedge clock) begin
      ranked_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (ranked_results_due.size() == 0) begin
            note_mismatch($sformatf("unexpected result: index %0d score %0d last %0b",
                                    rsp_class_index, rsp_kept_score, rsp_result_last));
         end else begin
            want = ranked_results_due.pop_front();
            results_checked++;
            if (rsp_class_index !== want.class_index ||
                rsp_kept_score !== want.kept_score ||
                rsp_result_last !== want.result_last) begin
               note_mismatch($sformatf(
                  "expected index %0d score %0d last %0b, got index %0d score %0d last %0b",
                  want.class_index, $signed(want.kept_score), want.result_last,
                  rsp_class_index, rsp_kept_score, rsp_result_last));
            end
         end
      end
   end

   // Any transfer on either channel or on the register port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d results still owed.",
                  quiet_cycles, ranked_results_due.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_access();
      test_directed_rows();
      test_long_row();
      test_random_rows();
      wait_for_drain();

      $display("Sent %0d scores in %0d rows over %0d keep_count writes, one row past the limit.",
               scores_sent, rows_closed, keep_writes);
      $display("Checked %0d ranked results; %0d mismatches.", results_checked, mismatch_count);
      if (mismatch_count == 0 && ranked_results_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
